>>> sv/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg: shared types and codes for the interval set manager
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

  // request opcodes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  // controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_PROC  = 6'b000100,
    S_EMIT2 = 6'b001000,
    S_FIN   = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch request, clear scan state
    logic rd;     // read table entry at scan index
    logic proc;   // process the entry just read
    logic emit2;  // write the pending second segment
    logic fin;    // final insert, commit or refuse, build response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;   // request changes nothing and needs no scan
    logic more;   // entries left to scan
    logic pend;   // current entry yields a second segment
  } sts_t;

endpackage

`default_nettype wire

>>> sv/ism_if.sv
// ----------------------------------------------------------------------------
// ism_if: request and response channels of the interval set manager
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ism_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] left;
  logic [31:0] right;

  modport source (output valid, output opcode, output left, output right, input ready);
  modport sink   (input valid, input opcode, input left, input right, output ready);
endinterface

interface ism_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        contained;
  logic [31:0] covered_length;
  logic [6:0]  segment_count;

  modport source (output valid, output status, output contained,
                  output covered_length, output segment_count, input ready);
  modport sink   (input valid, input status, input contained,
                  input covered_length, input segment_count, output ready);
endinterface

`default_nettype wire

>>> sv/ism_datapath.sv
// ----------------------------------------------------------------------------
// ism_datapath: segment table and scan datapath
// Two banks of the sorted table; a scan reads the live bank and writes the
// rebuilt table into the other one, and a commit flips the bank select.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_datapath #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire ism_pkg::cmd_t   cmd_i,
  output ism_pkg::sts_t        sts_o,
  input  wire  [1:0]           opcode_i,
  input  wire  [31:0]          left_i,
  input  wire  [31:0]          right_i,
  output logic [1:0]           status_o,
  output logic                 contained_o,
  output logic [31:0]          covered_length_o,
  output logic [6:0]           segment_count_o
);

  localparam int IDXW  = $clog2(MAX_SEGMENTS);
  localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
  localparam int DEPTH = 2 << IDXW;
  localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_SEGMENTS);

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // table banks
  coord_t mem_s [DEPTH];
  coord_t mem_e [DEPTH];

  logic [1:0]      op_q;
  coord_t          l_q, r_q;
  logic            bank_q;
  logic [CNTW-1:0] count_q, idx_q, n_q, n_d;
  coord_t          total_q, sum_q, sum_d;
  coord_t          ns_q, ns_d, ne_q, ne_d;
  logic            placed_q, placed_d, joined_q, joined_d;
  logic            split_q, split_d, found_q, found_d;
  coord_t          he_q, he_d;
  coord_t          pend_s_q, pend_e_q;
  coord_t          rd_s_q, rd_e_q;
  logic [1:0]      status_q, status_d;
  logic            hit_q, hit_d;

  logic            triv, refuse, commit;
  logic            wr_en, wr_ok, pend;
  coord_t          wr_s, wr_e;

  // request that changes nothing
  always_comb begin
    unique case (op_q)
      ism_pkg::OP_ADD, ism_pkg::OP_ERASE: triv = (r_q <= l_q);
      ism_pkg::OP_QUERY:                  triv = (r_q < l_q);
      default:                            triv = 1'b1;
    endcase
  end

  assign sts_o.skip = triv;
  assign sts_o.more = (idx_q < count_q);
  assign sts_o.pend = pend;

  assign refuse = !triv && (count_q >= MaxCnt) &&
                  (((op_q == ism_pkg::OP_ADD) && !joined_q) ||
                   ((op_q == ism_pkg::OP_ERASE) && split_q));
  assign commit = cmd_i.fin && !triv && !refuse &&
                  ((op_q == ism_pkg::OP_ADD) || (op_q == ism_pkg::OP_ERASE));

  // per-entry decisions and segment emission
  always_comb begin
    wr_en    = 1'b0;
    wr_s     = rd_s_q;
    wr_e     = rd_e_q;
    pend     = 1'b0;
    ns_d     = ns_q;
    ne_d     = ne_q;
    placed_d = placed_q;
    joined_d = joined_q;
    split_d  = split_q;
    found_d  = found_q;
    he_d     = he_q;
    if (cmd_i.proc) begin
      unique case (op_q)
        ism_pkg::OP_ADD: begin
          if (rd_s_q <= r_q && rd_e_q >= l_q) begin
            // overlapping or touching: widen the merged range
            joined_d = 1'b1;
            if (rd_s_q < ns_q) ns_d = rd_s_q;
            if (rd_e_q > ne_q) ne_d = rd_e_q;
          end else if (rd_s_q > r_q && !placed_q) begin
            // merged range goes first, this entry follows
            wr_en    = 1'b1;
            wr_s     = ns_q;
            wr_e     = ne_q;
            placed_d = 1'b1;
            pend     = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end
        ism_pkg::OP_ERASE: begin
          if (rd_e_q <= l_q || rd_s_q >= r_q) begin
            wr_en = 1'b1;
          end else if (rd_s_q < l_q) begin
            // keep the left piece; right piece too when split
            wr_en   = 1'b1;
            wr_e    = l_q;
            pend    = (rd_e_q > r_q);
            split_d = split_q || (rd_e_q > r_q);
          end else if (rd_e_q > r_q) begin
            wr_en = 1'b1;
            wr_s  = r_q;
          end
        end
        ism_pkg::OP_QUERY: begin
          if (rd_s_q <= l_q) begin
            found_d = 1'b1;
            he_d    = rd_e_q;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.emit2) begin
      wr_en = 1'b1;
      wr_s  = pend_s_q;
      wr_e  = pend_e_q;
    end else if (cmd_i.fin) begin
      wr_en = !triv && (op_q == ism_pkg::OP_ADD) && !placed_q;
      wr_s  = ns_q;
      wr_e  = ne_q;
    end
  end

  assign wr_ok = wr_en && (n_q < MaxCnt);
  assign n_d   = wr_ok ? n_q + CNTW'(1) : n_q;
  assign sum_d = wr_ok ? sum_q + (wr_e - wr_s) : sum_q;

  // response fields
  always_comb begin
    if ((op_q == ism_pkg::OP_QUERY) && triv) begin
      status_d = ism_pkg::ST_BAD_RANGE;
    end else if (refuse) begin
      status_d = ism_pkg::ST_FULL;
    end else begin
      status_d = ism_pkg::ST_OK;
    end
    hit_d = (op_q == ism_pkg::OP_QUERY) && !triv && found_q && (r_q <= he_q);
  end

  // table memories: write to the spare bank, registered read of the live one
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_s[{~bank_q, n_q[IDXW-1:0]}] <= wr_s;
      mem_e[{~bank_q, n_q[IDXW-1:0]}] <= wr_e;
    end
    if (cmd_i.rd) begin
      rd_s_q <= mem_s[{bank_q, idx_q[IDXW-1:0]}];
      rd_e_q <= mem_e[{bank_q, idx_q[IDXW-1:0]}];
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      l_q  <= COORD_WIDTH'(left_i);
      r_q  <= COORD_WIDTH'(right_i);
      ns_q <= COORD_WIDTH'(left_i);
      ne_q <= COORD_WIDTH'(right_i);
      sum_q <= '0;
      he_q  <= '0;
    end else begin
      ns_q  <= ns_d;
      ne_q  <= ne_d;
      sum_q <= sum_d;
      he_q  <= he_d;
    end
    // second segment: the entry itself for an add, the right piece for an erase
    if (cmd_i.proc) begin
      pend_s_q <= (op_q == ism_pkg::OP_ERASE) ? r_q : rd_s_q;
      pend_e_q <= rd_e_q;
    end
    if (cmd_i.fin) begin
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= 1'b0;
      count_q  <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      joined_q <= 1'b0;
      split_q  <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q    <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      joined_q <= 1'b0;
      split_q  <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.proc) idx_q <= idx_q + CNTW'(1);
      n_q      <= n_d;
      placed_q <= placed_d;
      joined_q <= joined_d;
      split_q  <= split_d;
      found_q  <= found_d;
      if (commit) begin
        bank_q  <= ~bank_q;
        count_q <= n_d;
        total_q <= sum_d;
      end
    end
  end

  assign status_o         = status_q;
  assign contained_o      = hit_q;
  assign covered_length_o = 32'(total_q);
  assign segment_count_o  = 7'(count_q);

  // checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("segment count above capacity");

  a_refuse_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && refuse) |=> ($stable(bank_q) && $stable(count_q) && $stable(total_q)))
    else $error("refused request changed the table");

  a_query_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && op_q == ism_pkg::OP_QUERY) |=> ($stable(bank_q) && $stable(count_q)))
    else $error("query changed the table");

  a_bad_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && status_d == ism_pkg::ST_BAD_RANGE) |-> !hit_d)
    else $error("bad range reported as contained");

endmodule

`default_nettype wire

>>> sv/ism_ctrl.sv
// ----------------------------------------------------------------------------
// ism_ctrl: sequencing state machine of the interval set manager
// Takes one request, walks the table entry by entry, then holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  wire            rsp_ready_i,
  input  wire ism_pkg::sts_t sts_i,
  output ism_pkg::cmd_t  cmd_o
);

  ism_pkg::state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ism_pkg::S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ism_pkg::S_RD;
        end
      end
      ism_pkg::S_RD: begin
        if (sts_i.skip || !sts_i.more) begin
          state_d = ism_pkg::S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ism_pkg::S_PROC;
        end
      end
      ism_pkg::S_PROC: begin
        cmd_o.proc = 1'b1;
        state_d    = sts_i.pend ? ism_pkg::S_EMIT2 : ism_pkg::S_RD;
      end
      ism_pkg::S_EMIT2: begin
        cmd_o.emit2 = 1'b1;
        state_d     = ism_pkg::S_RD;
      end
      ism_pkg::S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ism_pkg::S_RESP;
      end
      ism_pkg::S_RESP: begin
        if (rsp_ready_i) state_d = ism_pkg::S_IDLE;
      end
      default: state_d = ism_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ism_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ism_pkg::S_IDLE);
  assign rsp_valid_o = (state_q == ism_pkg::S_RESP);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(cmd_o) || (cmd_o == '0))
    else $error("more than one datapath command");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o && !req_ready_o)
    else $error("response dropped while stalled");

  a_fin_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> rsp_valid_o)
    else $error("finish not followed by response");

endmodule

`default_nettype wire

>>> sv/interval_set_manager.sv
// ----------------------------------------------------------------------------
// interval_set_manager: sorted set of disjoint half-open ranges
// Add merges a range, erase trims or splits, query tests containment.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries opcode, left and right; a request is taken when valid and
//   ready are high. ready is high only while the block is idle, so one
//   request is in flight at a time.
//   rsp_o returns one response per request: status, contained, and the
//   covered length and segment count after the operation.
//   The scan takes a read step and a process step per stored segment, and
//   an extra write step for each segment written twice in a step (insert
//   point of an add, split of an erase), then a finish step. The scan
//   does one table read per segment through the single read port.
//   Empty or unused requests skip the scan.
//   A new request is taken only in idle, after the response is taken.
//   Reset clears the segment count and covered length; the table memory is
//   not cleared and needs no clearing pass.
//   A stalled receiver holds the response in its register; no new request
//   is taken until the response has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_manager #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ism_req_if.sink   req_i,
  ism_rsp_if.source rsp_o
);

  ism_pkg::cmd_t cmd;
  ism_pkg::sts_t sts;

  ism_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ism_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (req_i.opcode),
    .left_i           (req_i.left),
    .right_i          (req_i.right),
    .status_o         (rsp_o.status),
    .contained_o      (rsp_o.contained),
    .covered_length_o (rsp_o.covered_length),
    .segment_count_o  (rsp_o.segment_count)
  );

endmodule

`default_nettype wire
